[design/layer_record_deframer_core_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the layer record deframer
// Shared property forms, clocked on clk and held off during rst.
// ----------------------------------------------------------------------------
`ifndef LAYER_RECORD_DEFRAMER_CORE_ASSERT_SVH
`define LAYER_RECORD_DEFRAMER_CORE_ASSERT_SVH

// Same-cycle implication.
`define LRD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lrd assertion failed");

// Next-cycle implication.
`define LRD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lrd assertion failed");

`endif

[design/lrd_pkg.sv]
// ----------------------------------------------------------------------------
// lrd_pkg
// Codes, command and status types shared by the deframer modules.
// ----------------------------------------------------------------------------
package lrd_pkg;

  // Event codes on the result channel
  localparam logic [2:0] EV_HEADER    = 3'd0;
  localparam logic [2:0] EV_OP        = 3'd1;
  localparam logic [2:0] EV_BAD_MAGIC = 3'd2;
  localparam logic [2:0] EV_BAD_TYPE  = 3'd3;
  localparam logic [2:0] EV_DONE      = 3'd4;

  // Op type bytes
  localparam logic [7:0] TYPE_CONV      = 8'd1;
  localparam logic [7:0] TYPE_BATCHNORM = 8'd2;
  localparam logic [7:0] TYPE_PRELU     = 8'd3;
  localparam logic [7:0] TYPE_ADD       = 8'd4;
  localparam logic [7:0] TYPE_GEMM      = 8'd5;
  localparam logic [7:0] TYPE_FLATTEN   = 8'd6;
  localparam logic [7:0] TYPE_SAVE      = 8'd7;
  localparam logic [7:0] TYPE_BLOCK     = 8'd8;

  // Op type classes by header layout
  localparam logic [2:0] TC_CONV  = 3'd0;
  localparam logic [2:0] TC_SIZE  = 3'd1;
  localparam logic [2:0] TC_GEMM  = 3'd2;
  localparam logic [2:0] TC_PLAIN = 3'd3;
  localparam logic [2:0] TC_BAD   = 3'd4;

  // Magic: three fixed bytes, then the version digit
  localparam logic [23:0] MAGIC_PREFIX = 24'h574646;
  localparam logic [7:0]  VER_CHAR_LO  = 8'h32;
  localparam logic [7:0]  VER_CHAR_HI  = 8'h34;
  localparam logic [7:0]  ASCII_ZERO   = 8'h30;
  localparam logic [2:0]  VER_BIAS_MIN = 3'd3;

  // Field accumulator operations
  localparam logic [1:0] ACC_NONE  = 2'd0;
  localparam logic [1:0] ACC_ADD   = 2'd1;
  localparam logic [1:0] ACC_CLEAR = 2'd2;

  // Register loads from the completed field
  localparam logic [3:0] LD_NONE    = 4'd0;
  localparam logic [3:0] LD_VERSION = 4'd1;
  localparam logic [3:0] LD_TOTAL   = 4'd2;
  localparam logic [3:0] LD_TYPE    = 4'd3;
  localparam logic [3:0] LD_COLS    = 4'd4;
  localparam logic [3:0] LD_ROWS    = 4'd5;
  localparam logic [3:0] LD_KH      = 4'd6;
  localparam logic [3:0] LD_KW      = 4'd7;
  localparam logic [3:0] LD_STRIDE  = 4'd8;
  localparam logic [3:0] LD_PAD     = 4'd9;
  localparam logic [3:0] LD_SIZE    = 4'd10;

  // Shared multiplier steps
  localparam logic [1:0] MUL_NONE = 2'd0;
  localparam logic [1:0] MUL_RC   = 2'd1;  // rows * cols
  localparam logic [1:0] MUL_KK   = 2'd2;  // kernel_h * kernel_w
  localparam logic [1:0] MUL_FIN  = 2'd3;  // partial * product

  typedef struct packed {
    logic [1:0] acc_op;
    logic [3:0] ld;
    logic       cnt_inc;
    logic       skip_dec;
    logic [1:0] mul_op;
    logic       add_len;
    logic       emit_en;
    logic [2:0] emit_ev;
    logic       emit_last;
  } ctl_cmd_t;

  typedef struct packed {
    logic [2:0] field_idx;
    logic       magic_ok;
    logic [2:0] type_class;
    logic       value_zero;
    logic       last_op;
    logic       skip_one;
    logic       skip_zero;
  } dp_status_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [2:0]  version;
    logic [31:0] count;
    logic [7:0]  op_type;
    logic [31:0] rows;
    logic [31:0] cols;
    logic [15:0] kernel_h;
    logic [15:0] kernel_w;
    logic [15:0] stride;
    logic [15:0] padding;
    logic        last;
  } result_t;

endpackage

[design/lrd_if.sv]
// ----------------------------------------------------------------------------
// lrd_if
// Byte and result channels of the deframer, valid/ready handshake.
// ----------------------------------------------------------------------------
interface lrd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first;

  modport source (output valid, output data_byte, output first, input ready);
  modport sink (input valid, input data_byte, input first, output ready);
endinterface

interface lrd_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic [2:0]  version;
  logic [31:0] count;
  logic [7:0]  op_type;
  logic [31:0] rows;
  logic [31:0] cols;
  logic [15:0] kernel_h;
  logic [15:0] kernel_w;
  logic [15:0] stride;
  logic [15:0] padding;
  logic        last;

  modport source (output valid, output event_res, output version, output count,
                  output op_type, output rows, output cols, output kernel_h,
                  output kernel_w, output stride, output padding, output last,
                  input ready);
  modport sink (input valid, input event_res, input version, input count,
                input op_type, input rows, input cols, input kernel_h,
                input kernel_w, input stride, input padding, input last,
                output ready);
endinterface

[design/lrd_datapath.sv]
// ----------------------------------------------------------------------------
// lrd_datapath
// Field assembly, held op header, op counters, payload length and result
// register of the deframer.
// ----------------------------------------------------------------------------
module lrd_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [7:0]           data_byte,
  input  logic                 first,
  input  lrd_pkg::ctl_cmd_t    cmd,
  output lrd_pkg::dp_status_t  status,
  output lrd_pkg::result_t     res
);
  import lrd_pkg::*;

  logic [2:0]  field_idx, field_idx_next;
  logic [31:0] field_acc, field_acc_next;
  logic [2:0]  format_version, format_version_next;
  logic [31:0] total_ops, total_ops_next;
  logic [31:0] op_counter, op_counter_next;
  logic [7:0]  current_type, current_type_next;
  logic [31:0] held_rows, held_rows_next;
  logic [31:0] held_cols, held_cols_next;
  logic [15:0] held_kernel_h, held_kernel_h_next;
  logic [15:0] held_kernel_w, held_kernel_w_next;
  logic [15:0] held_stride, held_stride_next;
  logic [15:0] held_padding, held_padding_next;
  logic [63:0] skip_remaining, skip_remaining_next;
  logic [63:0] mul_prod;
  logic [31:0] mul_partial;

  logic [2:0]  idx_eff;
  logic [31:0] acc_eff;
  logic [31:0] value;
  logic [7:0]  ver_byte;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_full;
  logic [63:0] len_addend;
  logic [64:0] len_sum;

  // A new stream starts from an empty field
  assign idx_eff  = first ? 3'd0 : field_idx;
  assign acc_eff  = first ? 32'd0 : field_acc;
  assign value    = acc_eff | ({24'd0, data_byte} << {idx_eff[1:0], 3'b000});
  assign ver_byte = value[31:24] - ASCII_ZERO;

  always_comb begin
    status.field_idx  = idx_eff;
    status.magic_ok   = (value[23:0] == MAGIC_PREFIX) && (value[31:24] >= VER_CHAR_LO) &&
                        (value[31:24] <= VER_CHAR_HI);
    status.value_zero = (value == 32'd0);
    status.last_op    = ((op_counter + 32'd1) == total_ops);
    status.skip_one   = (skip_remaining == 64'd1);
    status.skip_zero  = (skip_remaining == 64'd0);
    case (data_byte)
      TYPE_CONV:                                         status.type_class = TC_CONV;
      TYPE_BATCHNORM, TYPE_PRELU:                        status.type_class = TC_SIZE;
      TYPE_GEMM:                                         status.type_class = TC_GEMM;
      TYPE_ADD, TYPE_FLATTEN, TYPE_SAVE, TYPE_BLOCK:     status.type_class = TC_PLAIN;
      default:                                           status.type_class = TC_BAD;
    endcase
  end

  // Shared 32x32 multiplier
  always_comb begin
    case (cmd.mul_op)
      MUL_KK: begin
        mul_a = {16'd0, held_kernel_h};
        mul_b = {16'd0, held_kernel_w};
      end
      MUL_FIN: begin
        mul_a = mul_partial;
        mul_b = mul_prod[31:0];
      end
      default: begin
        mul_a = held_rows;
        mul_b = held_cols;
      end
    endcase
  end
  assign mul_full = mul_a * mul_b;

  // Bias term: 8 bytes per held row; conv before version 3 carries 4 per output channel
  always_comb begin
    if (current_type == TYPE_CONV && format_version < VER_BIAS_MIN)
      len_addend = {30'd0, held_rows, 2'b00};
    else
      len_addend = {29'd0, held_rows, 3'b000};
  end
  assign len_sum = {1'b0, mul_prod} + {1'b0, len_addend};

  always_comb begin
    field_idx_next      = field_idx;
    field_acc_next      = field_acc;
    format_version_next = format_version;
    total_ops_next      = total_ops;
    op_counter_next     = op_counter;
    current_type_next   = current_type;
    held_rows_next      = held_rows;
    held_cols_next      = held_cols;
    held_kernel_h_next  = held_kernel_h;
    held_kernel_w_next  = held_kernel_w;
    held_stride_next    = held_stride;
    held_padding_next   = held_padding;
    skip_remaining_next = skip_remaining;

    case (cmd.acc_op)
      ACC_ADD: begin
        field_idx_next = idx_eff + 3'd1;
        field_acc_next = value;
      end
      ACC_CLEAR: begin
        field_idx_next = 3'd0;
        field_acc_next = 32'd0;
      end
      default: ;
    endcase

    case (cmd.ld)
      LD_VERSION: format_version_next = status.magic_ok ? ver_byte[2:0] : 3'd0;
      LD_TOTAL: begin
        total_ops_next  = value;
        op_counter_next = 32'd0;
      end
      LD_TYPE: begin
        current_type_next   = data_byte;
        held_rows_next      = 32'd0;
        held_cols_next      = 32'd0;
        held_kernel_h_next  = 16'd0;
        held_kernel_w_next  = 16'd0;
        held_stride_next    = 16'd0;
        held_padding_next   = 16'd0;
        skip_remaining_next = 64'd0;
      end
      LD_COLS:   held_cols_next     = value;
      LD_ROWS:   held_rows_next     = value;
      LD_KH:     held_kernel_h_next = value[15:0];
      LD_KW:     held_kernel_w_next = value[15:0];
      LD_STRIDE: held_stride_next   = value[15:0];
      LD_PAD:    held_padding_next  = value[15:0];
      LD_SIZE: begin
        held_rows_next = value;
        if (current_type == TYPE_BATCHNORM)
          skip_remaining_next = {29'd0, value, 3'b000};
        else
          skip_remaining_next = {30'd0, value, 2'b00};
      end
      default: ;
    endcase

    if (cmd.cnt_inc)
      op_counter_next = op_counter + 32'd1;
    if (cmd.skip_dec)
      skip_remaining_next = skip_remaining - 64'd1;
    if (cmd.add_len)
      skip_remaining_next = len_sum[64] ? {64{1'b1}} : len_sum[63:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      field_idx      <= 3'd0;
      field_acc      <= 32'd0;
      format_version <= 3'd0;
      total_ops      <= 32'd0;
      op_counter     <= 32'd0;
      skip_remaining <= 64'd0;
    end else begin
      field_idx      <= field_idx_next;
      field_acc      <= field_acc_next;
      format_version <= format_version_next;
      total_ops      <= total_ops_next;
      op_counter     <= op_counter_next;
      skip_remaining <= skip_remaining_next;
    end
  end

  always_ff @(posedge clk) begin
    current_type  <= current_type_next;
    held_rows     <= held_rows_next;
    held_cols     <= held_cols_next;
    held_kernel_h <= held_kernel_h_next;
    held_kernel_w <= held_kernel_w_next;
    held_stride   <= held_stride_next;
    held_padding  <= held_padding_next;
    case (cmd.mul_op)
      MUL_RC, MUL_FIN: mul_prod <= mul_full;
      MUL_KK: begin
        mul_partial <= mul_prod[31:0];
        mul_prod    <= mul_full;
      end
      default: ;
    endcase
  end

  // Result register: loads post-edge values; op count is the pre-increment one
  always_ff @(posedge clk) begin
    if (cmd.emit_en) begin
      res.event_res <= cmd.emit_ev;
      res.version   <= (cmd.emit_ev == EV_BAD_MAGIC) ? 3'd0 : format_version_next;
      res.last      <= cmd.emit_last;
      case (cmd.emit_ev)
        EV_HEADER, EV_DONE:  res.count <= total_ops_next;
        EV_OP, EV_BAD_TYPE:  res.count <= op_counter;
        default:             res.count <= 32'd0;
      endcase
      if (cmd.emit_ev == EV_OP || cmd.emit_ev == EV_BAD_TYPE) begin
        res.op_type  <= current_type_next;
        res.rows     <= held_rows_next;
        res.cols     <= held_cols_next;
        res.kernel_h <= held_kernel_h_next;
        res.kernel_w <= held_kernel_w_next;
        res.stride   <= held_stride_next;
        res.padding  <= held_padding_next;
      end else begin
        res.op_type  <= 8'd0;
        res.rows     <= 32'd0;
        res.cols     <= 32'd0;
        res.kernel_h <= 16'd0;
        res.kernel_w <= 16'd0;
        res.stride   <= 16'd0;
        res.padding  <= 16'd0;
      end
    end
  end

endmodule

[design/lrd_ctrl.sv]
// ----------------------------------------------------------------------------
// lrd_ctrl
// Parse phase and sequencer of the deframer; drives the datapath commands
// and both handshakes.
// ----------------------------------------------------------------------------
`include "layer_record_deframer_core_assert.svh"

module lrd_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_first,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  lrd_pkg::dp_status_t  status,
  output lrd_pkg::ctl_cmd_t    cmd
);
  import lrd_pkg::*;

  // Parse phases
  localparam logic [3:0] PH_MAGIC  = 4'd0;
  localparam logic [3:0] PH_COUNT  = 4'd1;
  localparam logic [3:0] PH_TYPE   = 4'd2;
  localparam logic [3:0] PH_CIN    = 4'd3;
  localparam logic [3:0] PH_COUT   = 4'd4;
  localparam logic [3:0] PH_KH     = 4'd5;
  localparam logic [3:0] PH_KW     = 4'd6;
  localparam logic [3:0] PH_STRIDE = 4'd7;
  localparam logic [3:0] PH_PAD    = 4'd8;
  localparam logic [3:0] PH_SIZE   = 4'd9;
  localparam logic [3:0] PH_GEMM_N = 4'd10;
  localparam logic [3:0] PH_GEMM_K = 4'd11;
  localparam logic [3:0] PH_SKIP   = 4'd12;
  localparam logic [3:0] PH_HALT   = 4'd13;

  // Sequencer states
  localparam logic [2:0] S_IN      = 3'd0;
  localparam logic [2:0] S_MUL_RC  = 3'd1;
  localparam logic [2:0] S_MUL_KK  = 3'd2;
  localparam logic [2:0] S_MUL_FIN = 3'd3;
  localparam logic [2:0] S_ADD     = 3'd4;
  localparam logic [2:0] S_OP      = 3'd5;
  localparam logic [2:0] S_SECOND  = 3'd6;

  logic [3:0] phase, phase_next;
  logic [2:0] seq, seq_next;
  logic [3:0] ph_eff;
  logic [2:0] need;
  logic       field_done;
  logic       out_free;
  logic       accept;

  assign out_free   = !out_valid || out_ready;
  assign in_ready   = (seq == S_IN) && out_free;
  assign accept     = in_valid && in_ready;
  assign ph_eff     = in_first ? PH_MAGIC : phase;
  assign need       = (ph_eff inside {PH_MAGIC, PH_COUNT, PH_GEMM_N, PH_GEMM_K}) ? 3'd4 : 3'd2;
  assign field_done = (status.field_idx + 3'd1) >= need;

  always_comb begin
    cmd        = '0;
    phase_next = phase;
    seq_next   = seq;

    case (seq)
      S_IN: begin
        if (accept) begin
          phase_next = ph_eff;
          case (ph_eff)
            PH_HALT: ;
            PH_SKIP: begin
              cmd.skip_dec = 1'b1;
              if (status.skip_one) begin
                cmd.cnt_inc = 1'b1;
                if (status.last_op) begin
                  cmd.emit_en   = 1'b1;
                  cmd.emit_ev   = EV_DONE;
                  cmd.emit_last = 1'b1;
                  phase_next    = PH_HALT;
                end else begin
                  phase_next = PH_TYPE;
                end
              end
            end
            PH_TYPE: begin
              cmd.ld     = LD_TYPE;
              cmd.acc_op = ACC_CLEAR;
              case (status.type_class)
                TC_CONV: phase_next = PH_CIN;
                TC_SIZE: phase_next = PH_SIZE;
                TC_GEMM: phase_next = PH_GEMM_N;
                TC_PLAIN: begin
                  cmd.emit_en = 1'b1;
                  cmd.emit_ev = EV_OP;
                  cmd.cnt_inc = 1'b1;
                  if (status.last_op) begin
                    seq_next   = S_SECOND;
                    phase_next = PH_HALT;
                  end else begin
                    cmd.emit_last = 1'b1;
                    phase_next    = PH_TYPE;
                  end
                end
                default: begin
                  cmd.emit_en   = 1'b1;
                  cmd.emit_ev   = EV_BAD_TYPE;
                  cmd.emit_last = 1'b1;
                  phase_next    = PH_HALT;
                end
              endcase
            end
            default: begin
              if (!field_done) begin
                cmd.acc_op = ACC_ADD;
              end else begin
                cmd.acc_op = ACC_CLEAR;
                case (ph_eff)
                  PH_MAGIC: begin
                    cmd.ld = LD_VERSION;
                    if (status.magic_ok) begin
                      phase_next = PH_COUNT;
                    end else begin
                      cmd.emit_en   = 1'b1;
                      cmd.emit_ev   = EV_BAD_MAGIC;
                      cmd.emit_last = 1'b1;
                      phase_next    = PH_HALT;
                    end
                  end
                  PH_COUNT: begin
                    cmd.ld      = LD_TOTAL;
                    cmd.emit_en = 1'b1;
                    cmd.emit_ev = EV_HEADER;
                    if (status.value_zero) begin
                      seq_next   = S_SECOND;
                      phase_next = PH_HALT;
                    end else begin
                      cmd.emit_last = 1'b1;
                      phase_next    = PH_TYPE;
                    end
                  end
                  PH_CIN: begin
                    cmd.ld     = LD_COLS;
                    phase_next = PH_COUT;
                  end
                  PH_COUT: begin
                    cmd.ld     = LD_ROWS;
                    phase_next = PH_KH;
                  end
                  PH_KH: begin
                    cmd.ld     = LD_KH;
                    phase_next = PH_KW;
                  end
                  PH_KW: begin
                    cmd.ld     = LD_KW;
                    phase_next = PH_STRIDE;
                  end
                  PH_STRIDE: begin
                    cmd.ld     = LD_STRIDE;
                    phase_next = PH_PAD;
                  end
                  PH_PAD: begin
                    cmd.ld   = LD_PAD;
                    seq_next = S_MUL_RC;
                  end
                  PH_SIZE: begin
                    cmd.ld      = LD_SIZE;
                    cmd.emit_en = 1'b1;
                    cmd.emit_ev = EV_OP;
                    if (status.value_zero) begin
                      cmd.cnt_inc = 1'b1;
                      if (status.last_op) begin
                        seq_next   = S_SECOND;
                        phase_next = PH_HALT;
                      end else begin
                        cmd.emit_last = 1'b1;
                        phase_next    = PH_TYPE;
                      end
                    end else begin
                      cmd.emit_last = 1'b1;
                      phase_next    = PH_SKIP;
                    end
                  end
                  PH_GEMM_N: begin
                    cmd.ld     = LD_ROWS;
                    phase_next = PH_GEMM_K;
                  end
                  PH_GEMM_K: begin
                    cmd.ld   = LD_COLS;
                    seq_next = S_MUL_RC;
                  end
                  default: ;
                endcase
              end
            end
          endcase
        end
      end
      S_MUL_RC: begin
        cmd.mul_op = MUL_RC;
        seq_next   = (phase == PH_PAD) ? S_MUL_KK : S_ADD;
      end
      S_MUL_KK: begin
        cmd.mul_op = MUL_KK;
        seq_next   = S_MUL_FIN;
      end
      S_MUL_FIN: begin
        cmd.mul_op = MUL_FIN;
        seq_next   = S_ADD;
      end
      S_ADD: begin
        cmd.add_len = 1'b1;
        seq_next    = S_OP;
      end
      S_OP: begin
        if (out_free) begin
          cmd.emit_en = 1'b1;
          cmd.emit_ev = EV_OP;
          seq_next    = S_IN;
          if (status.skip_zero) begin
            cmd.cnt_inc = 1'b1;
            if (status.last_op) begin
              seq_next   = S_SECOND;
              phase_next = PH_HALT;
            end else begin
              cmd.emit_last = 1'b1;
              phase_next    = PH_TYPE;
            end
          end else begin
            cmd.emit_last = 1'b1;
            phase_next    = PH_SKIP;
          end
        end
      end
      S_SECOND: begin
        if (out_free) begin
          cmd.emit_en   = 1'b1;
          cmd.emit_ev   = EV_DONE;
          cmd.emit_last = 1'b1;
          seq_next      = S_IN;
        end
      end
      default: seq_next = S_IN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_MAGIC;
      seq       <= S_IN;
      out_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      seq   <= seq_next;
      if (cmd.emit_en)
        out_valid <= 1'b1;
      else if (out_ready)
        out_valid <= 1'b0;
    end
  end

  `LRD_ASSERT_IMP(a_second_halts, seq == S_SECOND, phase == PH_HALT)
  `LRD_ASSERT_NEXT(a_early_then_done, cmd.emit_en && !cmd.emit_last, seq == S_SECOND)
  `LRD_ASSERT_IMP(a_len_phase, seq != S_IN && seq != S_SECOND, phase == PH_PAD || phase == PH_GEMM_K)
  `LRD_ASSERT_IMP(a_halt_silent, accept && ph_eff == PH_HALT, !cmd.emit_en)

endmodule

[design/layer_record_deframer_core.sv]
// ----------------------------------------------------------------------------
// layer_record_deframer_core
// Weight-file stream deframer: magic and op count, typed op headers, payload
// skipping, with header, op, error and done reports.
// Throughput: one byte per cycle while results are taken as they appear and no
// header length or second result is pending. A result is registered; one that a
// byte causes directly shows in the cycle after that byte; a byte with two
// results holds the input off while the second waits. Conv and gemm headers pass
// the shared 32x32 multiplier, then a 64-bit saturating add, before the op report.
// Reset (rst, synchronous): parser waits for the magic, no result pending.
// ----------------------------------------------------------------------------
module layer_record_deframer_core (
  input  logic clk,
  input  logic rst,
  lrd_byte_if.sink     bytes,
  lrd_result_if.source results
);
  import lrd_pkg::*;

  // Controller and datapath exchange only commands and status.
  ctl_cmd_t   cmd;
  dp_status_t status;
  result_t    res;
  logic       out_valid;

  // Controller: parse phase, length sequencer, and both handshakes. The
  // input is held off while a header length is being computed, or while a
  // second result (always done) waits for the output register.
  lrd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (bytes.valid),
    .in_first  (bytes.first),
    .in_ready  (bytes.ready),
    .out_valid (out_valid),
    .out_ready (results.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath: field assembly, held header, op counters, payload length via
  // the shared multiplier, and the result register.
  lrd_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .data_byte (bytes.data_byte),
    .first     (bytes.first),
    .cmd       (cmd),
    .status    (status),
    .res       (res)
  );

  // Drive the result beat straight from the result register.
  assign results.valid     = out_valid;
  assign results.event_res = res.event_res;
  assign results.version   = res.version;
  assign results.count     = res.count;
  assign results.op_type   = res.op_type;
  assign results.rows      = res.rows;
  assign results.cols      = res.cols;
  assign results.kernel_h  = res.kernel_h;
  assign results.kernel_w  = res.kernel_w;
  assign results.stride    = res.stride;
  assign results.padding   = res.padding;
  assign results.last      = res.last;

endmodule
